[hdl/chd_pkg.sv]
// Shared constants, types and helpers for the canonical Huffman decoder.
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

  localparam int MaxSymBits = 13;
  localparam int MaxCodeLen = 24;
  localparam int SymW       = 13;
  localparam int LenW       = 5;
  localparam int CodeW      = 24;
  localparam int CntW       = 14;
  localparam int NumLen     = MaxCodeLen + 1;
  localparam int AddrW      = MaxSymBits;
  localparam int AlphaMax   = 1 << MaxSymBits;
  localparam int ByteW      = 8;
  localparam int BitCntW    = 4;
  localparam int SbitsW     = 4;

  localparam logic [0:0] RegSymbolBits = 1'b0;
  localparam logic [SbitsW-1:0] SymbolBitsRst = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_DECODE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_SYMBOL  = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUILT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_BUILD,
    TS_BDONE,
    TS_DECODE
  } top_state_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_COUNT,
    BS_PREFIX,
    BS_PLACE
  } build_state_e;

  typedef struct packed {
    logic [CodeW-1:0] first;
    logic [CntW-1:0]  count;
    logic [CntW-1:0]  offset;
  } len_entry_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [SymW-1:0]  data;
  } sym_wr_t;

  typedef struct packed {
    logic            valid;
    logic [SymW-1:0] symbol;
    status_e         status;
    logic            last;
  } result_t;

  // symbol width as used: 0 acts as 1, large values clip
  function automatic logic [SbitsW-1:0] sat_sym_bits(input logic [SbitsW-1:0] b);
    logic [SbitsW-1:0] r;
    r = b;
    if (b == '0) r = SbitsW'(1);
    else if (b > SbitsW'(MaxSymBits)) r = SbitsW'(MaxSymBits);
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/chd_if.sv]
// Request and result channel interfaces of the canonical Huffman decoder.
`timescale 1ns / 1ps
`default_nettype none
interface chd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [12:0] symbol_index;
  logic [4:0]  code_length;
  logic [7:0]  data_byte;
  logic [3:0]  bit_count;
  modport source (output valid, opcode, symbol_index, code_length, data_byte, bit_count,
                  input ready);
  modport sink (input valid, opcode, symbol_index, code_length, data_byte, bit_count,
                output ready);
endinterface

interface chd_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] symbol;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, symbol, status, last, input ready);
  modport sink (input valid, symbol, status, last, output ready);
endinterface
`default_nettype wire

[hdl/canonical_huffman_decoder.sv]
// Load writes one code length; build runs count, prefix and place passes.
// Decode walks bit_count bits: the shift register moves one bit per cycle, except
// while a found result waits on a full output. Throughput is set by this loop.
// Result register decouples output; a request waits while one item is at work.
// After reset all 8192 entries of the length memory are cleared; no request is
// taken meanwhile (configuration writes are).
`timescale 1ns / 1ps
`default_nettype none
module canonical_huffman_decoder import chd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  chd_req_if.sink     req_i,
  chd_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  top_state_e state_q, state_d;

  logic [SbitsW-1:0] sbits_q;
  logic [SbitsW-1:0] sbits_eff;
  logic              acc, do_load, do_build, do_dec;
  logic [LenW-1:0]   clen_sat;
  logic [BitCntW-1:0] cnt_sat;

  logic              b_ready, b_done;
  len_entry_t        lk_entry;
  logic [LenW-1:0]   lk_len, top_len;
  sym_wr_t           sym_wr;
  result_t           dres;
  logic              d_done;

  logic              ov_q;
  logic [SymW-1:0]   osym_q;
  status_e           ostat_q;
  logic              olast_q;
  logic              can_load, bres_load;

  assign pready = 1'b1;
  assign prdata = {{(32 - SbitsW){1'b0}}, sbits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sbits_q <= SymbolBitsRst;
    else if (psel && penable && pwrite && paddr[2] == RegSymbolBits)
      sbits_q <= pwdata[SbitsW-1:0];
  end

  assign sbits_eff = sat_sym_bits(sbits_q);

  assign req_i.ready = (state_q == TS_IDLE) && b_ready;
  assign acc      = req_i.valid && req_i.ready;
  assign do_load  = acc && (req_i.opcode == OP_LOAD);
  assign do_build = acc && (req_i.opcode == OP_BUILD);
  assign do_dec   = acc && (req_i.opcode == OP_DECODE);
  assign clen_sat = (req_i.code_length > LenW'(MaxCodeLen)) ? LenW'(MaxCodeLen)
                                                           : req_i.code_length;
  assign cnt_sat  = (req_i.bit_count > BitCntW'(ByteW)) ? BitCntW'(ByteW) : req_i.bit_count;

  assign can_load  = !ov_q || rsp_o.ready;
  assign bres_load = (state_q == TS_BDONE) && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= TS_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      TS_IDLE: begin
        if (do_build)    state_d = TS_BUILD;
        else if (do_dec) state_d = TS_DECODE;
      end
      TS_BUILD:  if (b_done) state_d = TS_BDONE;
      TS_BDONE:  if (can_load) state_d = TS_IDLE;
      TS_DECODE: if (d_done) state_d = TS_IDLE;
      default:   state_d = TS_IDLE;
    endcase
  end

  chd_build u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sym_bits_i (sbits_eff),
    .load_i     (do_load),
    .load_idx_i (req_i.symbol_index),
    .load_len_i (clen_sat),
    .build_i    (do_build),
    .lk_len_i   (lk_len),
    .lk_entry_o (lk_entry),
    .top_len_o  (top_len),
    .sym_wr_o   (sym_wr),
    .ready_o    (b_ready),
    .done_o     (b_done)
  );

  chd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (do_dec),
    .byte_i     (req_i.data_byte),
    .cnt_i      (cnt_sat),
    .clear_i    (do_build),
    .entry_i    (lk_entry),
    .top_len_i  (top_len),
    .sym_wr_i   (sym_wr),
    .can_load_i (can_load),
    .lk_len_o   (lk_len),
    .res_o      (dres),
    .done_o     (d_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (bres_load || dres.valid) ov_q <= 1'b1;
    else if (rsp_o.ready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (bres_load) begin
      osym_q  <= '0;
      ostat_q <= ST_BUILT;
      olast_q <= 1'b1;
    end else if (dres.valid) begin
      osym_q  <= dres.symbol;
      ostat_q <= dres.status;
      olast_q <= dres.last;
    end
  end

  assign rsp_o.valid  = ov_q;
  assign rsp_o.symbol = osym_q;
  assign rsp_o.status = ostat_q;
  assign rsp_o.last   = olast_q;

  a_build_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ostat_q == ST_BUILT) |-> olast_q)
    else $error("build result without last flag");

  a_no_dec_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TS_BUILD) |-> !dres.valid)
    else $error("decode result during table build");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !rsp_o.ready) |=> (ov_q && $stable(osym_q) && $stable(ostat_q) &&
                                $stable(olast_q)))
    else $error("result changed while waiting");

endmodule
`default_nettype wire

[hdl/chd_build.sv]
// Code length memory and the canonical code table builder.
`timescale 1ns / 1ps
`default_nettype none
module chd_build import chd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SbitsW-1:0] sym_bits_i,
  input  logic              load_i,
  input  logic [SymW-1:0]   load_idx_i,
  input  logic [LenW-1:0]   load_len_i,
  input  logic              build_i,
  input  logic [LenW-1:0]   lk_len_i,
  output len_entry_t        lk_entry_o,
  output logic [LenW-1:0]   top_len_o,
  output sym_wr_t           sym_wr_o,
  output logic              ready_o,
  output logic              done_o
);

  build_state_e state_q, state_d;

  logic [LenW-1:0]  len_mem [AlphaMax];
  logic [LenW-1:0]  len_rd_q;
  logic [AddrW-1:0] rsym_q;
  logic             rv_q, rv_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic [CntW-1:0]  alpha;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [LenW-1:0]  mem_wdata;

  logic [CntW-1:0]  count_q  [NumLen];
  logic [CntW-1:0]  offset_q [NumLen];
  logic [CodeW-1:0] first_q  [NumLen];
  logic [CntW-1:0]  next_q   [NumLen];
  logic [LenW-1:0]  top_q;
  logic [LenW-1:0]  lidx_q;
  logic [CntW-1:0]  pos_q;
  logic [CodeW-1:0] code_q;
  logic [CodeW-1:0] code_sum;
  logic [CodeW-1:0] code_new;
  logic [LenW-1:0]  lprev;

  assign alpha = CntW'(1) << sym_bits_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) len_mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      len_rd_q <= len_mem[scan_q[AddrW-1:0]];
      rsym_q   <= scan_q[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_CLEAR;
      scan_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      rv_q    <= rv_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    rv_d      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = scan_q[AddrW-1:0];
    mem_wdata = '0;
    done_o    = 1'b0;
    case (state_q)
      BS_CLEAR: begin
        mem_we = 1'b1;
        scan_d = scan_q + CntW'(1);
        if (scan_q == CntW'(AlphaMax - 1)) begin
          scan_d  = '0;
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (load_i && (CntW'(load_idx_i) < alpha)) begin
          mem_we    = 1'b1;
          mem_waddr = load_idx_i[AddrW-1:0];
          mem_wdata = load_len_i;
        end
        if (build_i) begin
          scan_d  = '0;
          state_d = BS_COUNT;
        end
      end
      BS_COUNT, BS_PLACE: begin
        if (scan_q < alpha) begin
          mem_re = 1'b1;
          rv_d   = 1'b1;
          scan_d = scan_q + CntW'(1);
        end else if (!rv_q) begin
          scan_d = '0;
          if (state_q == BS_COUNT) begin
            state_d = BS_PREFIX;
          end else begin
            state_d = BS_IDLE;
            done_o  = 1'b1;
          end
        end
      end
      BS_PREFIX: begin
        if (lidx_q == LenW'(MaxCodeLen)) state_d = BS_PLACE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // codes step up within a length and shift left into the next length
  assign lprev    = lidx_q - LenW'(1);
  assign code_sum = code_q + CodeW'(count_q[lprev]);
  assign code_new = {code_sum[CodeW-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLen; i++) begin
        count_q[i]  <= '0;
        offset_q[i] <= '0;
        first_q[i]  <= '0;
      end
      top_q  <= '0;
      lidx_q <= LenW'(1);
      pos_q  <= '0;
      code_q <= '0;
    end else begin
      if (state_q == BS_IDLE && build_i) begin
        for (int i = 0; i < NumLen; i++) count_q[i] <= '0;
        top_q  <= '0;
        lidx_q <= LenW'(1);
        pos_q  <= '0;
        code_q <= '0;
      end
      if (state_q == BS_COUNT && rv_q && len_rd_q != '0)
        count_q[len_rd_q] <= count_q[len_rd_q] + CntW'(1);
      if (state_q == BS_PREFIX) begin
        offset_q[lidx_q] <= pos_q;
        first_q[lidx_q]  <= code_new;
        code_q           <= code_new;
        pos_q            <= pos_q + count_q[lidx_q];
        if (count_q[lidx_q] != '0) top_q <= lidx_q;
        lidx_q           <= lidx_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BS_PREFIX) next_q[lidx_q] <= pos_q;
    if (state_q == BS_PLACE && rv_q && len_rd_q != '0)
      next_q[len_rd_q] <= next_q[len_rd_q] + CntW'(1);
  end

  assign sym_wr_o.en   = (state_q == BS_PLACE) && rv_q && (len_rd_q != '0);
  assign sym_wr_o.addr = next_q[len_rd_q][AddrW-1:0];
  assign sym_wr_o.data = SymW'(rsym_q);

  assign lk_entry_o.first  = first_q[lk_len_i];
  assign lk_entry_o.count  = count_q[lk_len_i];
  assign lk_entry_o.offset = offset_q[lk_len_i];
  assign top_len_o = top_q;
  assign ready_o   = (state_q == BS_IDLE);

  a_prefix_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_PREFIX) |-> !rv_q)
    else $error("length read still in flight at prefix pass");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> ready_o)
    else $error("builder not idle after build done");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= CntW'(AlphaMax))
    else $error("scan index beyond alphabet");

endmodule
`default_nettype wire

[hdl/chd_decode.sv]
// Bit-serial decoder: shifts one bit per cycle unless stalled and matches codes.
`timescale 1ns / 1ps
`default_nettype none
module chd_decode import chd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ByteW-1:0]   byte_i,
  input  logic [BitCntW-1:0] cnt_i,
  input  logic               clear_i,
  input  len_entry_t         entry_i,
  input  logic [LenW-1:0]    top_len_i,
  input  sym_wr_t            sym_wr_i,
  input  logic               can_load_i,
  output logic [LenW-1:0]    lk_len_o,
  output result_t            res_o,
  output logic               done_o
);

  logic [SymW-1:0]    sym_mem [AlphaMax];
  logic [SymW-1:0]    rd_q;
  logic               busy_q;
  logic [ByteW-1:0]   sh_q;
  logic [BitCntW-1:0] rem_q;
  logic [CodeW-1:0]   pc_q;
  logic [LenW-1:0]    pl_q;
  logic               pend_q;
  logic               pmem_q;
  status_e            pstat_q;

  logic [CodeW-1:0] code;
  logic [LenW-1:0]  lnext;
  logic [CodeW-1:0] diff;
  logic [CntW-1:0]  rd_sum;
  logic             match, hit, step, flush;

  assign code     = {pc_q[CodeW-2:0], sh_q[ByteW-1]};
  assign lnext    = (pl_q == LenW'(MaxCodeLen)) ? pl_q : pl_q + LenW'(1);
  assign lk_len_o = lnext;
  assign diff     = code - entry_i.first;
  assign match    = (entry_i.count != '0) && (code >= entry_i.first) &&
                    (diff < CodeW'(entry_i.count));
  assign hit      = match || (lnext >= top_len_i);
  assign rd_sum   = entry_i.offset + diff[CntW-1:0];

  // a found result waits as pending until the next one shows or the bits run out
  assign step  = busy_q && (rem_q != '0) && !(hit && pend_q && !can_load_i);
  assign flush = busy_q && (rem_q == '0) && (!pend_q || can_load_i);

  assign res_o.valid  = pend_q && ((step && hit) || flush);
  assign res_o.symbol = pmem_q ? rd_q : '0;
  assign res_o.status = pstat_q;
  assign res_o.last   = flush;
  assign done_o       = flush;

  always_ff @(posedge clk_i) begin
    if (sym_wr_i.en) sym_mem[sym_wr_i.addr] <= sym_wr_i.data;
    if (step && match) rd_q <= sym_mem[rd_sum[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= byte_i;
      rem_q <= cnt_i;
    end else if (step) begin
      sh_q  <= {sh_q[ByteW-2:0], 1'b0};
      rem_q <= rem_q - BitCntW'(1);
    end
    if (step && hit) begin
      pmem_q  <= match;
      pstat_q <= match ? ST_SYMBOL : ST_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      pc_q   <= '0;
      pl_q   <= '0;
    end else begin
      if (start_i) busy_q <= 1'b1;
      if (clear_i) begin
        pc_q <= '0;
        pl_q <= '0;
      end
      if (step) begin
        if (hit) begin
          pc_q   <= '0;
          pl_q   <= '0;
          pend_q <= 1'b1;
        end else begin
          pc_q <= code;
          pl_q <= lnext;
        end
      end
      if (flush) begin
        busy_q <= 1'b0;
        pend_q <= 1'b0;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pl_q <= LenW'(MaxCodeLen))
    else $error("partial code length beyond longest code");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> can_load_i)
    else $error("result pushed while output register full");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q <= BitCntW'(ByteW)))
    else $error("bit count beyond one byte");

endmodule
`default_nettype wire
